@@ hdl/dmbp_pkg.sv @@
// Package for the DNS message boundary parser: item types, status codes,
// walk phases and fixed byte counts. No dependencies.
`default_nettype none

package dmbp_pkg;

    // One input item: a message byte and its restart flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_flag;
    } byte_item_t;

    // One result item
    typedef struct packed {
        logic [1:0]  status;
        logic        element_kind;
        logic [17:0] element_number;
        logic [15:0] byte_offset;
    } result_item_t;

    // Status codes
    localparam logic [1:0] STATUS_IDLE      = 2'd0;
    localparam logic [1:0] STATUS_ELEMENT   = 2'd1;
    localparam logic [1:0] STATUS_DONE      = 2'd2;
    localparam logic [1:0] STATUS_MALFORMED = 2'd3;

    // Element kinds
    localparam logic KIND_QUESTION = 1'b0;
    localparam logic KIND_RECORD   = 1'b1;

    // Label length byte top bits
    localparam logic [1:0] LABEL_PLAIN    = 2'b00;
    localparam logic [1:0] LABEL_POINTER  = 2'b11;

    // Fixed byte counts of the wire format
    localparam logic [15:0] HEADER_BYTES = 16'd12;
    localparam logic [15:0] QFIXED_BYTES = 16'd4;
    localparam logic [15:0] RFIXED_BYTES = 16'd10;
    localparam logic [15:0] LAST_OFFSET  = 16'hFFFF;

    // Walk phases
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_HEADER = 8'b0000_0010,
        PH_NAME   = 8'b0000_0100,
        PH_LABEL  = 8'b0000_1000,
        PH_PTRLO  = 8'b0001_0000,
        PH_FIXED  = 8'b0010_0000,
        PH_RDATA  = 8'b0100_0000,
        PH_HALT   = 8'b1000_0000
    } phase_t;

endpackage

`default_nettype wire

@@ hdl/dmbp_walker.sv @@
// Message walker: phase, offset and count registers plus the per-byte
// step logic that yields one result item. Depends on dmbp_pkg.
`default_nettype none

module dmbp_walker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire dmbp_pkg::byte_item_t  item,
    output dmbp_pkg::result_item_t     result
);

    dmbp_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [15:0] off_reg, off_next, off_cur;
    logic [15:0] qleft_reg, qleft_next, qleft_cur;
    logic [17:0] rleft_reg, rleft_next, rleft_cur;
    logic [17:0] elem_reg, elem_next, elem_cur;
    logic [15:0] skip_reg, skip_next, skip_cur;
    logic [15:0] lstart_reg, lstart_next, lstart_cur;
    logic [7:0]  hi_reg, hi_next, hi_cur;

    logic        start;
    logic [7:0]  b;
    logic        finish;
    logic        kind;
    logic [15:0] word;
    logic [15:0] skip_dec;
    logic [15:0] qleft_dec;

    assign start = item.start_flag;
    assign b     = item.data_byte;

    // Restart from reset values on a start byte, but with the phase set to the header
    always_comb
    begin
        if (start)
        begin
            phase_cur  = dmbp_pkg::PH_HEADER;
            off_cur    = '0;
            qleft_cur  = '0;
            rleft_cur  = '0;
            elem_cur   = '0;
            skip_cur   = '0;
            lstart_cur = '0;
            hi_cur     = '0;
        end
        else
        begin
            phase_cur  = phase_reg;
            off_cur    = off_reg;
            qleft_cur  = qleft_reg;
            rleft_cur  = rleft_reg;
            elem_cur   = elem_reg;
            skip_cur   = skip_reg;
            lstart_cur = lstart_reg;
            hi_cur     = hi_reg;
        end
    end

    assign word      = {hi_cur, b};
    assign skip_dec  = skip_cur - 16'd1;
    assign kind      = (qleft_cur == '0) ? dmbp_pkg::KIND_RECORD : dmbp_pkg::KIND_QUESTION;
    assign qleft_dec = qleft_cur - 16'd1;

    // Step one byte through the walk
    always_comb
    begin
        phase_next  = phase_cur;
        off_next    = off_cur;
        qleft_next  = qleft_cur;
        rleft_next  = rleft_cur;
        elem_next   = elem_cur;
        skip_next   = skip_cur;
        lstart_next = lstart_cur;
        hi_next     = hi_cur;
        finish      = 1'b0;
        result      = '0;
        result.status = dmbp_pkg::STATUS_IDLE;

        if (!start && (phase_reg == dmbp_pkg::PH_IDLE || phase_reg == dmbp_pkg::PH_HALT))
        begin
            // outside a message: drop the byte
        end
        else if (!start && off_reg == dmbp_pkg::LAST_OFFSET)
        begin
            phase_next         = dmbp_pkg::PH_HALT;
            result.status      = dmbp_pkg::STATUS_MALFORMED;
            result.byte_offset = dmbp_pkg::LAST_OFFSET;
        end
        else
        begin
            off_next = off_cur + 16'd1;
            unique case (phase_cur)
                dmbp_pkg::PH_HEADER:
                begin
                    // capture QDCOUNT and the sum of the record counts
                    if (off_cur >= 16'd4 && !off_cur[0])
                        hi_next = b;
                    else if (off_cur == 16'd5)
                        qleft_next = word;
                    else if (off_cur == 16'd7 || off_cur == 16'd9 || off_cur == 16'd11)
                        rleft_next = rleft_cur + {2'b00, word};
                    if (off_cur == dmbp_pkg::HEADER_BYTES - 16'd1)
                    begin
                        elem_next = '0;
                        if (qleft_next == '0 && rleft_next == '0)
                        begin
                            phase_next         = dmbp_pkg::PH_HALT;
                            result.status      = dmbp_pkg::STATUS_DONE;
                            result.byte_offset = dmbp_pkg::HEADER_BYTES;
                        end
                        else
                        begin
                            phase_next = dmbp_pkg::PH_NAME;
                            skip_next  = 16'd1;
                        end
                    end
                end
                dmbp_pkg::PH_NAME:
                begin
                    // label length byte, pointer or root
                    skip_next = '0;
                    if (b[7:6] != dmbp_pkg::LABEL_PLAIN && b[7:6] != dmbp_pkg::LABEL_POINTER)
                    begin
                        phase_next         = dmbp_pkg::PH_HALT;
                        result.status      = dmbp_pkg::STATUS_MALFORMED;
                        result.byte_offset = off_cur;
                    end
                    else
                    begin
                        if (b[7:6] == dmbp_pkg::LABEL_POINTER)
                        begin
                            hi_next     = {2'b00, b[5:0]};
                            lstart_next = off_cur;
                            phase_next  = dmbp_pkg::PH_PTRLO;
                        end
                        else if (b == 8'd0)
                        begin
                            phase_next = dmbp_pkg::PH_FIXED;
                            skip_next  = (kind == dmbp_pkg::KIND_QUESTION) ?
                                         dmbp_pkg::QFIXED_BYTES : dmbp_pkg::RFIXED_BYTES;
                        end
                        else
                        begin
                            phase_next = dmbp_pkg::PH_LABEL;
                            skip_next  = {8'd0, b};
                        end
                        if (skip_cur == 16'd1)
                        begin
                            result.status         = dmbp_pkg::STATUS_ELEMENT;
                            result.element_kind   = kind;
                            result.element_number = elem_cur;
                            result.byte_offset    = off_cur;
                        end
                    end
                end
                dmbp_pkg::PH_LABEL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        phase_next = dmbp_pkg::PH_NAME;
                end
                dmbp_pkg::PH_PTRLO:
                begin
                    // only backward pointers are legal
                    if (word >= lstart_cur)
                    begin
                        phase_next         = dmbp_pkg::PH_HALT;
                        result.status      = dmbp_pkg::STATUS_MALFORMED;
                        result.byte_offset = off_cur;
                    end
                    else
                    begin
                        phase_next = dmbp_pkg::PH_FIXED;
                        skip_next  = (kind == dmbp_pkg::KIND_QUESTION) ?
                                     dmbp_pkg::QFIXED_BYTES : dmbp_pkg::RFIXED_BYTES;
                    end
                end
                dmbp_pkg::PH_FIXED:
                begin
                    // a record's last two fixed bytes hold RDLENGTH
                    if (kind == dmbp_pkg::KIND_RECORD && skip_cur == 16'd1)
                    begin
                        if (word == '0)
                            finish = 1'b1;
                        else
                        begin
                            phase_next = dmbp_pkg::PH_RDATA;
                            skip_next  = word;
                        end
                    end
                    else
                    begin
                        if (kind == dmbp_pkg::KIND_RECORD && skip_cur == 16'd2)
                            hi_next = b;
                        skip_next = skip_dec;
                        if (skip_dec == '0)
                            finish = 1'b1;
                    end
                end
                dmbp_pkg::PH_RDATA:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        finish = 1'b1;
                end
                default:
                begin
                    phase_next = dmbp_pkg::PH_HALT;
                end
            endcase

            // Close the element and move to the next one or finish
            if (finish)
            begin
                if (qleft_cur != '0)
                begin
                    qleft_next = qleft_dec;
                    elem_next  = (qleft_dec != '0) ? elem_cur + 18'd1 : '0;
                end
                else
                begin
                    rleft_next = rleft_cur - 18'd1;
                    elem_next  = elem_cur + 18'd1;
                end
                if (qleft_next == '0 && rleft_next == '0)
                begin
                    phase_next         = dmbp_pkg::PH_HALT;
                    result.status      = dmbp_pkg::STATUS_DONE;
                    result.byte_offset = off_cur + 16'd1;
                end
                else
                begin
                    phase_next = dmbp_pkg::PH_NAME;
                    skip_next  = 16'd1;
                end
            end
        end
    end

    // Advance the walk state once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dmbp_pkg::PH_IDLE;
            off_reg    <= '0;
            qleft_reg  <= '0;
            rleft_reg  <= '0;
            elem_reg   <= '0;
            skip_reg   <= '0;
            lstart_reg <= '0;
            hi_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            qleft_reg  <= qleft_next;
            rleft_reg  <= rleft_next;
            elem_reg   <= elem_next;
            skip_reg   <= skip_next;
            lstart_reg <= lstart_next;
            hi_reg     <= hi_next;
        end
    end

    // A completion or malformed report leaves the walker halted
    a_done_halts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (result.status == dmbp_pkg::STATUS_DONE ||
                 result.status == dmbp_pkg::STATUS_MALFORMED)
        |=> phase_reg == dmbp_pkg::PH_HALT)
        else $error("walker not halted after done or malformed");

    // A start byte is offset zero of the header
    a_start_header: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.start_flag |=> phase_reg == dmbp_pkg::PH_HEADER && off_reg == 16'd1)
        else $error("start byte did not restart the header");

    // Inside a label there is always at least one byte left
    a_label_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dmbp_pkg::PH_LABEL |-> skip_reg != '0)
        else $error("label phase with empty count");

endmodule

`default_nettype wire

@@ hdl/dns_message_boundary_parser_core.sv @@
// Top level of the DNS message boundary parser: input register, walker and
// result register. Depends on dmbp_pkg and dmbp_walker.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  byte     | byte_valid / byte_stall    | byte_item   (data_byte, start_flag)
//  result   | result_valid / result_stall| result_item (status, kind, number, offset)
//
// One byte is taken per cycle unless a stalled result holds it; each byte gives exactly
// one result item. Path: input register, then the walker step into the result register.
// The walker's phase and counter registers update in the same cycle as the result is written.
// Reset returns the walker to idle; bytes without a start flag are then ignored.
// A stalled result holds the result register and, once the input register is full,
// raises byte_stall.
`default_nettype none

module dns_message_boundary_parser_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire dmbp_pkg::byte_item_t  byte_item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output dmbp_pkg::result_item_t     result_item
);

    logic                   in_valid_reg;
    dmbp_pkg::byte_item_t   in_item_reg;
    logic                   out_valid_reg;
    dmbp_pkg::result_item_t out_item_reg;
    dmbp_pkg::result_item_t step_result;
    logic                   advance;

    // Move the held byte into the result register when there is room
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;

    dmbp_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (step_result)
    );

    // Control flags of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!byte_stall)
                in_valid_reg <= byte_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
            in_item_reg <= byte_item;
        if (advance)
            out_item_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // Stall is raised only while an item is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> in_valid_reg)
        else $error("byte_stall without a held item");

    // Every walker step shows up as a result item
    a_step_shown: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("walker step lost");

    // A taken result with nothing behind it empties the register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !advance |=> !result_valid)
        else $error("result repeated");

endmodule

`default_nettype wire
